### hw/rtl/u2p_pkg.sv
package u2p_pkg;

    localparam int SEQ_MAX_BYTES = 16;
    localparam int RESULT_CAP    = 16;
    localparam int SEQ_CAP       = (SEQ_MAX_BYTES < RESULT_CAP) ? SEQ_MAX_BYTES : RESULT_CAP;
    localparam int CNT_W         = $clog2(SEQ_CAP + 1);

    localparam int MAKE_MAX = 8;
    localparam int IDX_W    = 3;
    localparam int LEN_W    = 4;

    localparam logic [7:0] BASE_LIMIT   = 8'hA4;
    localparam logic [7:0] MOD_FIRST    = 8'hE0;
    localparam logic [7:0] MOD_LAST     = 8'hE7;
    localparam logic [7:0] CODE_LSHIFT  = 8'hE1;
    localparam logic [7:0] CODE_RSHIFT  = 8'hE5;
    localparam logic [7:0] CODE_PAUSE   = 8'h48;
    localparam logic [7:0] CODE_PRTSC   = 8'h46;
    localparam logic [7:0] BYTE_EXT     = 8'hE0;
    localparam logic [7:0] BYTE_BREAK   = 8'hF0;
    localparam logic [7:0] MISC_RST     = 8'd232;

    typedef struct packed {
        logic [MAKE_MAX-1:0][7:0] bytes;
        logic [LEN_W-1:0]         len;
        logic                     release_f;
    } t_desc;

    // upper byte E0: two byte entry
    localparam logic [15:0] BASE_ROM [0:163] = '{
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h001C, 16'h0032, 16'h0021, 16'h0023,
        16'h0024, 16'h002B, 16'h0034, 16'h0033, 16'h0043, 16'h003B, 16'h0042, 16'h004B,
        16'h003A, 16'h0031, 16'h0044, 16'h004D, 16'h0015, 16'h002D, 16'h001B, 16'h002C,
        16'h003C, 16'h002A, 16'h001D, 16'h0022, 16'h0035, 16'h001A, 16'h0016, 16'h001E,
        16'h0026, 16'h0025, 16'h002E, 16'h0036, 16'h003D, 16'h003E, 16'h0046, 16'h0045,
        16'h005A, 16'h0076, 16'h0066, 16'h000D, 16'h0029, 16'h004E, 16'h0055, 16'h0054,
        16'h005B, 16'h005D, 16'h005D, 16'h004C, 16'h0052, 16'h000E, 16'h0041, 16'h0049,
        16'h004A, 16'h0058, 16'h0005, 16'h0006, 16'h0004, 16'h000C, 16'h0003, 16'h000B,
        16'h0083, 16'h000A, 16'h0001, 16'h0009, 16'h0078, 16'h0007, 16'hE07C, 16'h007E,
        16'h0000, 16'hE070, 16'hE06C, 16'hE07D, 16'hE071, 16'hE069, 16'hE07A, 16'hE074,
        16'hE06B, 16'hE072, 16'hE075, 16'h0077, 16'hE04A, 16'h007C, 16'h007B, 16'h0079,
        16'hE05A, 16'h0069, 16'h0072, 16'h007A, 16'h006B, 16'h0073, 16'h0074, 16'h006C,
        16'h0075, 16'h007D, 16'h0070, 16'h0071, 16'h0061, 16'hE02F, 16'hE037, 16'h000F,
        16'h0008, 16'h0010, 16'h0018, 16'h0020, 16'h0028, 16'h0030, 16'h0038, 16'h0040,
        16'h0048, 16'h0050, 16'h0057, 16'h005F, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hE023,
        16'hE032, 16'hE031, 16'h0000, 16'h0000, 16'h0000, 16'h006D, 16'h0000, 16'h0051,
        16'h0013, 16'h006A, 16'h0064, 16'h0067, 16'h0027, 16'h0000, 16'h0000, 16'h0000,
        16'h00F2, 16'h00F1, 16'h0063, 16'h0062, 16'h005F, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0084, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    localparam logic [15:0] MOD_ROM [0:7] = '{
        16'h0014, 16'h0012, 16'h0011, 16'hE01F, 16'hE014, 16'h0059, 16'hE011, 16'hE027
    };

    localparam logic [15:0] MISC_ROM [0:7] = '{
        16'hE07E, 16'hE032, 16'hE021, 16'hE023, 16'hE03B, 16'hE034, 16'hE04D, 16'hE015
    };

    localparam logic [7:0] PAUSE_MAKE [0:7] = '{
        8'hE1, 8'h14, 8'h77, 8'hE1, 8'hF0, 8'h14, 8'hF0, 8'h77
    };

    localparam logic [7:0] PRTSC_NOSHIFT [0:3] = '{8'hE0, 8'h12, 8'hE0, 8'h7C};

endpackage

### hw/rtl/u2p_front.sv
module u2p_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_in_valid,
    input  logic [7:0]          i_key_code,
    input  logic                i_is_release,
    input  logic                i_q_full,
    output logic                o_in_stall,
    output logic                o_push,
    output u2p_pkg::t_desc      o_desc
);

    logic [7:0]  r_misc_base;
    logic [1:0]  r_shift;
    logic [1:0]  n_shift;
    logic        accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        logic [15:0] entry;
        logic [8:0]  diff;
        logic        mapped;
        logic        in_base;
        logic        in_mod;
        logic        in_misc;

        diff    = {1'b0, i_key_code} - {1'b0, r_misc_base};
        in_base = (i_key_code < u2p_pkg::BASE_LIMIT);
        in_mod  = (i_key_code >= u2p_pkg::MOD_FIRST) && (i_key_code <= u2p_pkg::MOD_LAST);
        in_misc = ({1'b0, i_key_code} >= {1'b0, r_misc_base})
                  && ({1'b0, i_key_code} <= ({1'b0, r_misc_base} + 9'd7));
        mapped  = (i_key_code != 8'd0) && (in_base || in_mod || in_misc);

        if (in_base) begin
            entry = u2p_pkg::BASE_ROM[i_key_code];
        end else if (in_mod) begin
            entry = u2p_pkg::MOD_ROM[i_key_code[2:0]];
        end else begin
            entry = u2p_pkg::MISC_ROM[diff[2:0]];
        end

        o_desc           = '0;
        o_desc.release_f = i_is_release;
        if (entry[15:8] == u2p_pkg::BYTE_EXT) begin
            o_desc.bytes[0] = u2p_pkg::BYTE_EXT;
            o_desc.bytes[1] = entry[7:0];
            o_desc.len      = u2p_pkg::LEN_W'(2);
        end else begin
            o_desc.bytes[0] = entry[7:0];
            o_desc.len      = u2p_pkg::LEN_W'(1);
        end

        if (in_base && i_key_code == u2p_pkg::CODE_PAUSE) begin
            for (int i = 0; i < u2p_pkg::MAKE_MAX; i++) begin
                o_desc.bytes[i] = u2p_pkg::PAUSE_MAKE[i];
            end
            o_desc.len = u2p_pkg::LEN_W'(8);
        end

        // shift keys never hit print screen, so the held state is current
        if (i_key_code == u2p_pkg::CODE_PRTSC && r_shift == 2'b00) begin
            for (int i = 0; i < 4; i++) begin
                o_desc.bytes[i] = u2p_pkg::PRTSC_NOSHIFT[i];
            end
            o_desc.len = u2p_pkg::LEN_W'(4);
        end

        n_shift = r_shift;
        if (accept && mapped) begin
            if (i_key_code == u2p_pkg::CODE_LSHIFT) begin
                n_shift[0] = !i_is_release;
            end else if (i_key_code == u2p_pkg::CODE_RSHIFT) begin
                n_shift[1] = !i_is_release;
            end
        end

        o_push = accept && mapped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_misc_base <= u2p_pkg::MISC_RST;
            r_shift     <= 2'b00;
        end else begin
            if (i_cfg_we) begin
                r_misc_base <= i_cfg_data;
            end
            r_shift <= n_shift;
        end
    end

endmodule

### hw/rtl/u2p_queue.sv
module u2p_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  u2p_pkg::t_desc      i_desc,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output u2p_pkg::t_desc      o_desc
);

    u2p_pkg::t_desc r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/u2p_back.sv
module u2p_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  u2p_pkg::t_desc      i_desc,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [7:0]          o_scan_byte,
    output logic                o_last_byte
);

    u2p_pkg::t_desc                r_cur;
    logic                          r_busy;
    logic                          r_f0_sent;
    logic [u2p_pkg::IDX_W-1:0]     r_idx;
    logic [u2p_pkg::CNT_W-1:0]     r_cnt;
    logic                          r_out_valid;
    logic [7:0]                    r_out_byte;
    logic                          r_out_last;

    logic                          advance;
    logic [7:0]                    cur_byte;
    logic                          need_f0;
    logic                          seq_end;
    logic                          cap_end;

    assign o_pop    = !r_busy && !i_q_empty;
    assign advance  = r_busy && (!r_out_valid || !i_out_stall);
    assign cur_byte = r_cur.bytes[r_idx];
    assign need_f0  = r_cur.release_f && (cur_byte != u2p_pkg::BYTE_EXT) && !r_f0_sent;
    assign seq_end  = !need_f0 && ({1'b0, r_idx} == (r_cur.len - u2p_pkg::LEN_W'(1)));
    assign cap_end  = (r_cnt == u2p_pkg::CNT_W'(u2p_pkg::SEQ_CAP - 1));

    assign o_out_valid = r_out_valid;
    assign o_scan_byte = r_out_byte;
    assign o_last_byte = r_out_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_desc;
        end
        if (advance) begin
            r_out_byte <= need_f0 ? u2p_pkg::BYTE_BREAK : cur_byte;
            r_out_last <= seq_end || cap_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_f0_sent   <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy    <= 1'b1;
                r_f0_sent <= 1'b0;
                r_idx     <= '0;
                r_cnt     <= '0;
            end else if (advance) begin
                r_cnt <= r_cnt + u2p_pkg::CNT_W'(1);
                if (need_f0) begin
                    r_f0_sent <= 1'b1;
                end else begin
                    r_f0_sent <= 1'b0;
                    r_idx     <= r_idx + u2p_pkg::IDX_W'(1);
                end
                if (seq_end || cap_end) begin
                    r_busy <= 1'b0;
                end
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/usb_keycode_to_ps2_set2.sv
// A taken key event is queued, loaded into the emitter, then its first scan byte
// is registered out. Throughput: one byte per cycle while the output is not
// stalled; the emitter loads each event first, and an event spans up to 16 bytes.
// A two-entry event queue lets key events be taken while bytes are still draining.
// Reset (synchronous, active low): clears shift state and the queue, empties the
// output, and sets the media key base code to 0xE8.
module usb_keycode_to_ps2_set2 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_key_code,
    input  logic        i_is_release,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_scan_byte,
    output logic        o_last_byte
);

    u2p_pkg::t_desc push_desc;
    u2p_pkg::t_desc head_desc;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    u2p_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_key_code   (i_key_code),
        .i_is_release (i_is_release),
        .i_q_full     (q_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_desc       (push_desc)
    );

    u2p_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_desc  (head_desc)
    );

    u2p_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_desc      (head_desc),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_scan_byte (o_scan_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
